### src/ami_pkg.sv
// ami_pkg: widths, codes and the saturation helper for the affine inverse
// no dependencies; used by affine_matrix_inverse
package ami_pkg;

    localparam int DATA_W   = 32;
    localparam int EPS_W    = 16;
    localparam int COL_W    = 2;
    localparam int USER_W   = COL_W + 1;
    localparam int IN_BITS  = 12 * DATA_W;
    localparam int OUT_BITS = 4 * DATA_W;
    localparam int DET_W    = 64;
    localparam int WIDE_W   = 65;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    typedef logic [COL_W-1:0] t_col;
    localparam t_col COL_FIRST = 2'd0;
    localparam t_col COL_LAST  = 2'd2;

    localparam logic signed [WIDE_W-1:0] SAT_HI = 65'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -65'sd2147483648;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[DATA_W-1:0];
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

### src/ami_div.sv
// ami_div: pipelined restoring divider, one quotient bit per register stage
// standalone; instantiated by affine_matrix_inverse
module ami_div #(
    parameter int NW = 48,
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);

    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] r_den [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [NW-1:0] w_num_in;
        logic [NW-1:0] w_quo_in;
        logic [DW:0]   w_trial;
        logic [DW:0]   w_diff;
        logic          w_ge;

        // stage inputs: ports for the first stage, previous stage otherwise
        if (s == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_den_in = i_den;
            assign w_num_in = i_num;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_num_in = r_num[s-1];
            assign w_quo_in = r_quo[s-1];
        end

        // shift in the next numerator bit and try the subtraction
        assign w_trial = {w_rem_in, w_num_in[NW-1]};
        assign w_diff  = w_trial - {1'b0, w_den_in};
        assign w_ge    = (w_trial >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_den[s] <= w_den_in;
                r_num[s] <= {w_num_in[NW-2:0], 1'b0};
                r_quo[s] <= {w_quo_in[NW-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule

### src/affine_matrix_inverse.sv
// affine_matrix_inverse: inverse of a fixed-point affine transform, streamed by column
// depends on ami_pkg and ami_div
// One transform enters as an item and leaves as three result items, one per
// column of the inverse, the third with tlast set. The three result beats per
// transform on the output limit the sustained rate; the input side takes an
// item in any cycle while the pipeline has room. From acceptance to the first
// result an item passes five stages for cofactors and determinant, one stage
// per quotient bit in the nine parallel restoring dividers, and three stages
// for saturation and the translation. A determinant whose magnitude is at or
// below det_epsilon gives all-zero results with the singular flag set.
module affine_matrix_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: det_epsilon
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ami_pkg::EPS_W-1:0]     i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // c0r0, c0r1, c0r2, c1r0, c1r1, c1r2, c2r0, c2r1, c2r2, tx, ty, tz
    input  logic [ami_pkg::IN_BITS-1:0]   s_axis_tdata,
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // inv_r0, inv_r1, inv_r2, inv_trans
    output logic [ami_pkg::OUT_BITS-1:0]  m_axis_tdata,
    // column_index, singular
    output logic [ami_pkg::USER_W-1:0]    m_axis_tuser,
    output logic                          m_axis_tlast
);
    import ami_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int L  = NW + 8;

    // configuration register
    logic [EPS_W-1:0] r_eps;

    // pipeline control
    logic [L-1:0] r_v;
    logic         w_en;
    logic         w_beat;
    logic         w_ser_free;
    logic         w_load;

    // unpacked input
    logic signed [DATA_W-1:0] w_m [3][3];
    logic signed [DATA_W-1:0] w_t [3];

    // stage registers
    logic signed [DET_W-1:0]  r1_pa [3][3];
    logic signed [DET_W-1:0]  r1_pb [3][3];
    logic signed [DATA_W-1:0] r1_m0 [3];
    logic signed [DATA_W-1:0] r1_t  [3];

    logic signed [DATA_W-1:0] r2_cof [3][3];
    logic signed [DATA_W-1:0] r2_m0  [3];
    logic signed [DATA_W-1:0] r2_t   [3];

    logic signed [DET_W-1:0]  r3_dp  [3];
    logic signed [DATA_W-1:0] r3_cof [3][3];
    logic signed [DATA_W-1:0] r3_t   [3];

    logic signed [DET_W-1:0]  r4_det;
    logic signed [DATA_W-1:0] r4_cof [3][3];
    logic signed [DATA_W-1:0] r4_t   [3];

    logic [NW-1:0]            r5_num [3][3];
    logic                     r5_neg [3][3];
    logic [DET_W-1:0]         r5_den;
    logic                     r5_sing;
    logic signed [DATA_W-1:0] r5_t   [3];

    logic signed [DATA_W-1:0] r_dl_t    [NW][3];
    logic                     r_dl_neg  [NW][3][3];
    logic                     r_dl_sing [NW];
    logic [NW-1:0]            w_quo     [3][3];

    logic signed [DATA_W-1:0] r6_inv [3][3];
    logic signed [DATA_W-1:0] r6_t   [3];
    logic                     r6_sing;

    logic signed [DET_W-1:0]  r7_p   [3][3];
    logic signed [DATA_W-1:0] r7_inv [3][3];
    logic                     r7_sing;

    logic signed [DATA_W-1:0] r8_inv [3][3];
    logic signed [DATA_W-1:0] r8_it  [3];
    logic                     r8_sing;

    // output holding stage
    logic signed [DATA_W-1:0] r_o_inv [3][3];
    logic signed [DATA_W-1:0] r_o_it  [3];
    logic                     r_o_sing;
    logic                     r_sv;
    t_col                     r_cnt;

    // combinational helpers
    logic signed [WIDE_W-1:0] w_diff [3][3];
    logic signed [DET_W-1:0]  w_det;
    logic [DET_W-1:0]         w_det_mag;
    logic signed [DET_W-1:0]  w_sum [3];

    // configuration write, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_valid) begin
            r_eps <= i_cfg_data;
        end
    end

    // stall control: the whole pipeline moves when its last stage can drain
    assign w_beat     = r_sv && m_axis_tready;
    assign w_ser_free = !r_sv || (w_beat && (r_cnt == COL_LAST));
    assign w_en       = !r_v[L-1] || w_ser_free;
    assign w_load     = w_en && r_v[L-1];
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[L-2:0], s_axis_tvalid};
        end
    end

    // input unpacking, column major
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                w_m[r][c] = s_axis_tdata[(c*3+r)*DATA_W +: DATA_W];
            end
            w_t[c] = s_axis_tdata[(9+c)*DATA_W +: DATA_W];
        end
    end

    // stage 1: cofactor products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_pa[r][c] <= w_m[(r+1)%3][(c+1)%3] * w_m[(r+2)%3][(c+2)%3];
                    r1_pb[r][c] <= w_m[(r+1)%3][(c+2)%3] * w_m[(r+2)%3][(c+1)%3];
                end
                r1_m0[r] <= w_m[0][r];
                r1_t[r]  <= w_t[r];
            end
        end
    end

    // stage 2: cofactors, floored and saturated
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_diff[r][c] = (WIDE_W'(r1_pa[r][c]) - WIDE_W'(r1_pb[r][c])) >>> FRAC_BITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r2_cof[r][c] <= sat32(w_diff[r][c]);
                end
                r2_m0[r] <= r1_m0[r];
                r2_t[r]  <= r1_t[r];
            end
        end
    end

    // stage 3: row 0 expansion products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r3_dp[c] <= r2_m0[c] * r2_cof[0][c];
                r3_t[c]  <= r2_t[c];
            end
            r3_cof <= r2_cof;
        end
    end

    // stage 4: determinant
    assign w_det = (r3_dp[0] >>> FRAC_BITS) + (r3_dp[1] >>> FRAC_BITS)
                 + (r3_dp[2] >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_det <= w_det;
            r4_cof <= r3_cof;
            r4_t   <= r3_t;
        end
    end

    // stage 5: magnitudes and signs for the dividers, singular test
    assign w_det_mag = r4_det[DET_W-1] ? DET_W'(-r4_det) : DET_W'(r4_det);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    // inverse entry (r, c) comes from cofactor (c, r)
                    r5_num[r][c] <= NW'($unsigned(r4_cof[c][r][DATA_W-1] ?
                                        DATA_W'(-r4_cof[c][r]) : DATA_W'(r4_cof[c][r])))
                                    << FRAC_BITS;
                    r5_neg[r][c] <= r4_cof[c][r][DATA_W-1] ^ r4_det[DET_W-1];
                end
            end
            r5_den  <= w_det_mag;
            r5_sing <= (w_det_mag <= DET_W'(r_eps));
            r5_t    <= r4_t;
        end
    end

    // nine dividers in parallel
    for (genvar gr = 0; gr < 3; gr++) begin : g_row
        for (genvar gc = 0; gc < 3; gc++) begin : g_col
            ami_div #(
                .NW (NW),
                .DW (DET_W)
            ) u_div (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num (r5_num[gr][gc]),
                .i_den (r5_den),
                .o_quo (w_quo[gr][gc])
            );
        end
    end

    // side data travelling alongside the dividers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_t[0]    <= r5_t;
            r_dl_neg[0]  <= r5_neg;
            r_dl_sing[0] <= r5_sing;
            for (int s = 1; s < NW; s++) begin
                r_dl_t[s]    <= r_dl_t[s-1];
                r_dl_neg[s]  <= r_dl_neg[s-1];
                r_dl_sing[s] <= r_dl_sing[s-1];
            end
        end
    end

    // stage 6: signed, saturated inverse entries
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (r_dl_sing[NW-1]) begin
                        r6_inv[r][c] <= '0;
                    end else if (r_dl_neg[NW-1][r][c]) begin
                        r6_inv[r][c] <= sat32(-WIDE_W'(w_quo[r][c]));
                    end else begin
                        r6_inv[r][c] <= sat32(WIDE_W'(w_quo[r][c]));
                    end
                end
            end
            r6_t    <= r_dl_t[NW-1];
            r6_sing <= r_dl_sing[NW-1];
        end
    end

    // stage 7: inverse times translation products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r7_p[r][c] <= r6_inv[r][c] * r6_t[c];
                end
            end
            r7_inv  <= r6_inv;
            r7_sing <= r6_sing;
        end
    end

    // stage 8: negated, saturated inverse translation
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = (r7_p[r][0] >>> FRAC_BITS) + (r7_p[r][1] >>> FRAC_BITS)
                     + (r7_p[r][2] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                r8_it[r] <= sat32(-WIDE_W'(w_sum[r]));
            end
            r8_inv  <= r7_inv;
            r8_sing <= r7_sing;
        end
    end

    // output holding stage: one item becomes three column beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_cnt <= COL_FIRST;
        end else if (w_load) begin
            r_sv  <= 1'b1;
            r_cnt <= COL_FIRST;
        end else if (w_beat) begin
            if (r_cnt == COL_LAST) begin
                r_sv  <= 1'b0;
                r_cnt <= COL_FIRST;
            end else begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_inv  <= r8_inv;
            r_o_it   <= r8_it;
            r_o_sing <= r8_sing;
        end
    end

    // column select
    always_comb begin
        case (r_cnt)
            2'd0: begin
                m_axis_tdata = {r_o_it[0], r_o_inv[2][0], r_o_inv[1][0], r_o_inv[0][0]};
            end
            2'd1: begin
                m_axis_tdata = {r_o_it[1], r_o_inv[2][1], r_o_inv[1][1], r_o_inv[0][1]};
            end
            2'd2: begin
                m_axis_tdata = {r_o_it[2], r_o_inv[2][2], r_o_inv[1][2], r_o_inv[0][2]};
            end
            default: begin
                m_axis_tdata = '0;
            end
        endcase
    end

    assign m_axis_tvalid = r_sv;
    assign m_axis_tuser  = {r_o_sing, r_cnt};
    assign m_axis_tlast  = (r_cnt == COL_LAST);

`ifndef SYNTH
    // the column counter only runs while an item is held
    a_cnt_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != COL_FIRST) |-> r_sv)
        else $error("column counter active with no item held");

    // a singular result carries all-zero data
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[COL_W]) |-> (m_axis_tdata == '0))
        else $error("singular result with non-zero data");

    // a stalled pipeline keeps its last stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[L-1] && !w_en) |=> r_v[L-1])
        else $error("pipeline item lost during stall");

    // a finished column other than the last advances the counter
    a_beat_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && (r_cnt != COL_LAST)) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("column counter did not advance");
`endif

endmodule
